/* rtl/core/sssp_pkg.sv */
// ----------------------------------------------------------------------------
// Shortest path package
// Shared types and constants for the Bellman-Ford shortest path engine.
// ----------------------------------------------------------------------------
package sssp_pkg;

   localparam int unsigned VERTEX_W = 6;
   localparam int unsigned DIST_W   = 32;
   localparam int unsigned WEIGHT_W = 16;
   localparam int unsigned COUNT_W  = 7;
   localparam logic signed [DIST_W-1:0] INF_DIST = 32'sd100000000;

   typedef enum logic [1:0] {
      ACT_CLEAR = 2'd0,
      ACT_ADD   = 2'd1,
      ACT_RUN   = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef struct packed {
      logic [1:0]                 action;
      logic [VERTEX_W-1:0]        from_vertex;
      logic [VERTEX_W-1:0]        to_vertex;
      logic signed [WEIGHT_W-1:0] weight;
      logic [VERTEX_W-1:0]        source;
   } req_type;

   typedef struct packed {
      logic [VERTEX_W-1:0]      vertex;
      logic signed [DIST_W-1:0] distance;
      logic                     reachable;
      logic                     negative_cycle;
      logic                     edges_dropped;
      logic                     last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_RD,
      ST_WAIT,
      ST_DIST,
      ST_EVAL,
      ST_PASS,
      ST_OUT_RD,
      ST_OUT_WAIT,
      ST_OUT,
      ST_CYCLE
   } state_type;

endpackage

/* rtl/core/sssp_if.sv */
// ----------------------------------------------------------------------------
// Stream interface
// Valid/ready channel carrying one packed payload.
// ----------------------------------------------------------------------------
interface sssp_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/core/sssp_front.sv */
// ----------------------------------------------------------------------------
// Request front end
// Takes requests, drops unused actions and queues the rest for the engine.
// ----------------------------------------------------------------------------
module sssp_front (
   input  logic            clock,
   input  logic            reset,
   sssp_if.sink            req,
   output sssp_pkg::req_type q_data,
   output logic            q_valid,
   input  logic            q_pop
);
   import sssp_pkg::*;

   localparam int unsigned DEPTH = 2;

   req_type   slot_ff [DEPTH];
   logic      wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic      push;

   assign req.ready = (cnt_ff != 2'd2);
   assign push = req.valid && req.ready && (req.payload.action != ACT_NONE);
   assign q_valid = (cnt_ff != 2'd0);
   assign q_data = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff ^ push;
      rd_in  = rd_ff ^ q_pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= req.payload;
      end
   end
endmodule

/* rtl/core/sssp_engine.sv */
// ----------------------------------------------------------------------------
// Relaxation engine
// Edge table, distance memory and the Bellman-Ford pass sequencer.
// ----------------------------------------------------------------------------
module sssp_engine #(
   parameter int unsigned MAX_VERTICES = 64,
   parameter int unsigned MAX_EDGES    = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [sssp_pkg::COUNT_W-1:0] nv,
   input  sssp_pkg::req_type            q_data,
   input  logic                         q_valid,
   output logic                         q_pop,
   sssp_if.source                       rsp,
   output logic                         busy
);
   import sssp_pkg::*;

   localparam int unsigned EA_W  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int unsigned ET_W  = $clog2(MAX_EDGES + 1);
   localparam int unsigned VA_W  = $clog2(MAX_VERTICES);
   localparam int unsigned VC_W  = $clog2(MAX_VERTICES + 1);

   logic [VERTEX_W-1:0]        tail_mem   [MAX_EDGES];
   logic [VERTEX_W-1:0]        head_mem   [MAX_EDGES];
   logic signed [WEIGHT_W-1:0] weight_mem [MAX_EDGES];
   logic signed [DIST_W-1:0]   dist_mem   [MAX_VERTICES];
   logic [MAX_VERTICES-1:0]    reached_ff, reached_in;

   state_type state_ff, state_in;
   logic [ET_W-1:0]  total_ff, total_in;
   logic             ovf_ff, ovf_in;
   logic [ET_W-1:0]  e_ff, e_in;
   logic [VC_W-1:0]  pass_ff, pass_in;
   logic             chg_ff, chg_in;
   logic             check_ff, check_in;
   logic [VC_W-1:0]  v_ff, v_in;
   logic [VC_W-1:0]  nvl_ff, nvl_in;

   logic [VERTEX_W-1:0]        tail_q, head_q;
   logic signed [WEIGHT_W-1:0] wt_q;
   logic signed [DIST_W-1:0]   du_q, dv_q;
   logic signed [DIST_W+1:0]   cand;
   logic signed [DIST_W-1:0]   cand_sat;
   logic                       ok, better;
   rsp_type                    out_ff;
   logic                       out_v_ff;
   logic                       dwr;
   logic [VA_W-1:0]            dwa;
   logic signed [DIST_W-1:0]   dwd;

   assign busy = (state_ff != ST_IDLE) || out_v_ff;
   assign rsp.valid   = out_v_ff;
   assign rsp.payload = out_ff;

   // edge fields held from ST_WAIT; distances held in ST_DIST and ST_EVAL
   assign ok = ({1'b0, tail_q} < nvl_ff) && ({1'b0, head_q} < nvl_ff)
               && reached_ff[tail_q[VA_W-1:0]];
   assign cand = $signed({{2{du_q[DIST_W-1]}}, du_q})
                 + $signed({{(DIST_W+2-WEIGHT_W){wt_q[WEIGHT_W-1]}}, wt_q});
   assign cand_sat = (cand < -(34'sd2147483648)) ? {1'b1, {(DIST_W-1){1'b0}}}
                                                 : cand[DIST_W-1:0];
   assign better = !reached_ff[head_q[VA_W-1:0]]
                   || (cand < $signed({{2{dv_q[DIST_W-1]}}, dv_q}));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid && !out_v_ff) begin
               if (q_data.action == ACT_RUN) begin
                  state_in = ST_INIT;
               end
            end
         end
         ST_INIT: begin
            if ({1'b0, q_data.source} >= nvl_ff) state_in = ST_OUT_RD;
            else                                state_in = ST_RD;
         end
         ST_RD:   state_in = (e_ff >= total_ff) ? ST_PASS : ST_WAIT;
         ST_WAIT: state_in = ok ? ST_DIST : ST_RD;
         ST_DIST: state_in = ST_EVAL;
         ST_EVAL: state_in = ST_RD;
         ST_PASS: begin
            if (check_ff)                  state_in = chg_ff ? ST_CYCLE : ST_OUT_RD;
            else if (!chg_ff)              state_in = ST_OUT_RD;
            else                           state_in = ST_RD;
         end
         ST_OUT_RD:   state_in = ST_OUT_WAIT;
         ST_OUT_WAIT: state_in = ST_OUT;
         ST_OUT: begin
            if (rsp.ready || !out_v_ff) begin
               state_in = (v_ff + 1'b1 == nvl_ff) ? ST_IDLE : ST_OUT_RD;
            end
         end
         ST_CYCLE: if (!out_v_ff) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      q_pop = 1'b0;
      total_in = total_ff; ovf_in = ovf_ff; e_in = e_ff; pass_in = pass_ff;
      chg_in = chg_ff; check_in = check_ff; v_in = v_ff; nvl_in = nvl_ff;
      reached_in = reached_ff;
      dwr = 1'b0; dwa = head_q[VA_W-1:0]; dwd = cand_sat;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid && !out_v_ff) begin
               q_pop = (q_data.action != ACT_RUN);
               if (q_data.action == ACT_CLEAR) begin
                  total_in = '0; ovf_in = 1'b0;
               end else if (q_data.action == ACT_ADD) begin
                  if (total_ff < ET_W'(MAX_EDGES)) total_in = total_ff + 1'b1;
                  else                              ovf_in = 1'b1;
               end else begin
                  nvl_in = (nv == '0) ? VC_W'(1)
                         : (nv > COUNT_W'(MAX_VERTICES)) ? VC_W'(MAX_VERTICES)
                         : VC_W'(nv);
               end
            end
         end
         ST_INIT: begin
            q_pop = 1'b1;
            reached_in = '0;
            e_in = '0; pass_in = VC_W'(1); chg_in = 1'b0; v_in = '0;
            check_in = (nvl_ff == VC_W'(1));
            if ({1'b0, q_data.source} < nvl_ff) begin
               reached_in[q_data.source[VA_W-1:0]] = 1'b1;
               dwr = 1'b1; dwa = q_data.source[VA_W-1:0]; dwd = '0;
            end
         end
         ST_RD:   e_in = e_ff + 1'b1;
         ST_EVAL: begin
            if (better) begin
               chg_in = 1'b1;
               reached_in[head_q[VA_W-1:0]] = 1'b1;
               dwr = 1'b1;
            end
         end
         ST_PASS: begin
            e_in = '0; chg_in = 1'b0;
            if (pass_ff + 1'b1 >= nvl_ff) check_in = 1'b1;
            pass_in = pass_ff + 1'b1;
         end
         ST_OUT: if (rsp.ready || !out_v_ff) v_in = v_ff + 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; total_ff <= '0; ovf_ff <= 1'b0; e_ff <= '0;
         pass_ff <= '0; chg_ff <= 1'b0; check_ff <= 1'b0; v_ff <= '0;
         nvl_ff <= VC_W'(1); reached_ff <= '0; out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in; total_ff <= total_in; ovf_ff <= ovf_in; e_ff <= e_in;
         pass_ff <= pass_in; chg_ff <= chg_in; check_ff <= check_in; v_ff <= v_in;
         nvl_ff <= nvl_in; reached_ff <= reached_in;
         if (rsp.ready) out_v_ff <= 1'b0;
         if (state_ff == ST_OUT && (rsp.ready || !out_v_ff)) begin
            out_v_ff <= 1'b1;
            out_ff.vertex <= v_ff[VERTEX_W-1:0];
            out_ff.reachable <= reached_ff[v_ff[VA_W-1:0]];
            out_ff.distance <= reached_ff[v_ff[VA_W-1:0]] ? du_q : INF_DIST;
            out_ff.negative_cycle <= 1'b0;
            out_ff.edges_dropped <= ovf_ff;
            out_ff.last <= (v_ff + 1'b1 == nvl_ff);
         end else if (state_ff == ST_CYCLE && !out_v_ff) begin
            out_v_ff <= 1'b1;
            out_ff <= '{vertex: '0, distance: '0, reachable: 1'b0,
                        negative_cycle: 1'b1, edges_dropped: ovf_ff, last: 1'b1};
         end
      end
   end

   // edge table
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && q_valid && !out_v_ff && q_data.action == ACT_ADD
          && total_ff < ET_W'(MAX_EDGES)) begin
         tail_mem[total_ff[EA_W-1:0]]   <= q_data.from_vertex;
         head_mem[total_ff[EA_W-1:0]]   <= q_data.to_vertex;
         weight_mem[total_ff[EA_W-1:0]] <= q_data.weight;
      end
      if (state_ff == ST_RD) begin
         tail_q <= tail_mem[e_ff[EA_W-1:0]];
         head_q <= head_mem[e_ff[EA_W-1:0]];
         wt_q   <= weight_mem[e_ff[EA_W-1:0]];
      end
   end

   // distance memory: two read ports, one write; port A also serves the report
   always_ff @(posedge clock) begin
      if (dwr) dist_mem[dwa] <= dwd;
      if (state_ff == ST_WAIT) begin
         du_q <= dist_mem[tail_q[VA_W-1:0]];
         dv_q <= dist_mem[head_q[VA_W-1:0]];
      end else if (state_ff == ST_OUT_RD) begin
         du_q <= dist_mem[v_ff[VA_W-1:0]];
      end
   end
endmodule

/* rtl/core/single_source_shortest_path.sv */
// ----------------------------------------------------------------------------
// Single source shortest path
// Bellman-Ford over a stored edge table with early exit and cycle check.
// ----------------------------------------------------------------------------
// Add and clear are done by the engine in its idle state after queueing.
// A run reads each edge, evaluates only usable ones, ends each pass in a pass step,
// runs up to vertex_count passes, then reads out and reports each vertex in turn.
// The edge table read and the distance memory set the pace.
// Synchronous reset clears control state; tables need no clearing.
module single_source_shortest_path #(
   parameter int unsigned MAX_VERTICES = 64,
   parameter int unsigned MAX_EDGES    = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   sssp_if.sink                         req,
   sssp_if.source                       rsp,
   input  logic                         csr_write_enable,
   input  logic [sssp_pkg::COUNT_W-1:0] csr_write_data
);
   import sssp_pkg::*;

   logic [COUNT_W-1:0] vcount_ff;
   req_type            q_data;
   logic               q_valid, q_pop, busy;

   always_ff @(posedge clock) begin
      if (reset)                 vcount_ff <= COUNT_W'(64);
      else if (csr_write_enable) vcount_ff <= csr_write_data;
   end

   sssp_front u_front (
      .clock, .reset, .req, .q_data, .q_valid, .q_pop
   );

   sssp_engine #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_engine (
      .clock, .reset, .nv(vcount_ff), .q_data, .q_valid, .q_pop, .rsp, .busy
   );

   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("pop from empty queue");
   a_cycle_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.payload.negative_cycle |-> rsp.payload.last)
      else $error("cycle result not last");
   a_out_busy: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> busy) else $error("result while idle");
endmodule
